@@ rtl/snd_pkg.sv @@
// Shared constants, types and elaboration-time table builders for the
// sigmoid derivative pipeline. No dependencies.
package snd_pkg;

  localparam int TABLE_ADDR_BITS = 10;
  localparam int ROM_DEPTH       = 1 << TABLE_ADDR_BITS;
  localparam int SIG_W           = 17;
  localparam int POW_W           = 33;
  localparam int ACC_W           = 45;
  localparam int COEF_W          = 10;
  localparam int Y_W             = 18;
  localparam int NUM_TERMS       = 6;
  localparam int LATENCY         = 8;
  localparam int SERIES_TERMS    = 60;
  localparam int MAX_ROW         = 5;

  typedef logic [SIG_W-1:0]          sig_t;
  typedef logic [POW_W-1:0]          pow_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef sig_t                      rom_t [ROM_DEPTH];

  localparam coef_t COEF [NUM_TERMS][NUM_TERMS] = '{
    '{10'sd1,    10'sd0,   10'sd0,    10'sd0,   10'sd0,    10'sd0},
    '{10'sd1,   -10'sd1,   10'sd0,    10'sd0,   10'sd0,    10'sd0},
    '{10'sd1,   -10'sd3,   10'sd2,    10'sd0,   10'sd0,    10'sd0},
    '{10'sd1,   -10'sd7,   10'sd12,  -10'sd6,   10'sd0,    10'sd0},
    '{10'sd1,   -10'sd15,  10'sd50,  -10'sd60,  10'sd24,   10'sd0},
    '{10'sd1,   -10'sd31,  10'sd180, -10'sd390, 10'sd360, -10'sd120}
  };

  localparam logic signed [28:0] Y_MAX = 29'sd131071;
  localparam logic signed [28:0] Y_MIN = -29'sd131072;

  // Restoring division, used only while building the table.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-(mag/4096) in Q.30, truncated Taylor series.
  function automatic longint unsigned exp_neg_q30(longint unsigned mag);
    longint          sum;
    longint unsigned term;
    sum  = longint'(1) << 30;
    term = longint'(1) << 30;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      term = udiv64(term * mag, 64'(4096) * 64'(k));
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum);
  endfunction

  // Sigmoid at each segment center, rounded to Q0.16.
  function automatic rom_t build_rom();
    rom_t            rom;
    int              i;
    int              c;
    longint unsigned mag;
    longint unsigned e;
    longint unsigned d;
    longint unsigned s;
    for (int a = 0; a < ROM_DEPTH; a++) begin
      i   = (a < ROM_DEPTH / 2) ? a : a - ROM_DEPTH;
      c   = i * (1 << (16 - TABLE_ADDR_BITS)) + (1 << (15 - TABLE_ADDR_BITS));
      mag = longint'((c < 0) ? -c : c);
      e   = exp_neg_q30(mag);
      d   = (longint'(1) << 30) + e;
      if (c >= 0) s = udiv64((longint'(1) << 46) + (d >> 1), d);
      else        s = udiv64((e << 16) + (d >> 1), d);
      rom[a] = s[SIG_W-1:0];
    end
    return rom;
  endfunction

endpackage

@@ rtl/sigmoid_nth_derivative.sv @@
// Sigmoid n-th derivative pipeline: ROM lookup, power chain, coefficient sum,
// rounding and saturation. Depends on snd_pkg.
//
//   channel  | ports                          | transaction
//   ---------+--------------------------------+-------------------------------
//   sample   | start, busy, x_in[15:0]        | start high while busy low
//   result   | done, y_out[17:0]              | done high for one cycle
//   config   | cfg_we, cfg_data[2:0]          | cfg_we high at a clock edge
//
// One sample enters every cycle; its result is accepted at the clock edge
// that ends the cycle in which done is high. The pipeline has eight register
// stages: the registered ROM read, five stages of the power chain (one 33x17
// multiplier each), the last term and the final rounding stage. busy never
// rises: the receiver cannot stall, so nothing holds the pipeline. Reset
// (rst, synchronous) clears the valid bits and sets derivative_order to 0.
// Write the order only while the pipeline is empty.
module sigmoid_nth_derivative (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [15:0]        x_in,
  output logic                      done,
  output logic signed [17:0]        y_out,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_data
);

  localparam snd_pkg::rom_t SIG_ROM = snd_pkg::build_rom();
  localparam int NT = snd_pkg::NUM_TERMS;

  logic [2:0] derivative_order;
  logic [2:0] row_sel;
  logic [snd_pkg::TABLE_ADDR_BITS-1:0] addr;

  // Stage registers: index 0 holds the ROM output, 1..6 the sum chain.
  logic              vld   [NT+1];
  logic [2:0]        row_q [NT+1];
  snd_pkg::sig_t     s_q   [NT-1];
  snd_pkg::pow_t     p_q   [1:NT-1];
  snd_pkg::acc_t     acc_q [1:NT];

  snd_pkg::pow_t     p_in     [NT];
  snd_pkg::acc_t     acc_in   [NT];
  snd_pkg::pow_t     p_next   [1:NT-1];
  snd_pkg::acc_t     acc_next [1:NT];

  snd_pkg::acc_t            rsum;
  logic signed [28:0]       y_wide;
  logic signed [17:0]       y_next;

  assign busy = 1'b0;
  assign addr = x_in[15 -: snd_pkg::TABLE_ADDR_BITS];
  // Orders without a polynomial fall back to plain sigmoid.
  assign row_sel = (derivative_order > 3'(snd_pkg::MAX_ROW)) ? 3'd0 : derivative_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      derivative_order <= 3'd0;
    end else if (cfg_we) begin
      derivative_order <= cfg_data;
    end
  end

  // Power chain and running sum: stage j forms p(j+1) and adds term j.
  always_comb begin
    logic [49:0] prod;
    logic signed [43:0] term;
    for (int j = 0; j < NT; j++) begin
      p_in[j]   = (j == 0) ? {s_q[0], 16'd0} : p_q[(j == 0) ? 1 : j];
      acc_in[j] = (j == 0) ? '0 : acc_q[(j == 0) ? 1 : j];
    end
    for (int j = 1; j < NT; j++) begin
      prod      = 50'(p_in[j-1]) * 50'(s_q[j-1]);
      p_next[j] = snd_pkg::POW_W'((prod + 50'd32768) >> 16);
    end
    for (int j = 1; j <= NT; j++) begin
      term        = 44'(snd_pkg::COEF[row_q[j-1]][j-1]) * $signed({11'd0, p_in[j-1]});
      acc_next[j] = acc_in[j-1] + snd_pkg::ACC_W'(term);
    end
  end

  // Round Q0.32 to Q0.16 (floor after adding half), then clamp.
  always_comb begin
    rsum   = acc_q[NT] + snd_pkg::ACC_W'(32768);
    y_wide = rsum[snd_pkg::ACC_W-1:16];
    if (y_wide > snd_pkg::Y_MAX)      y_next = 18'sd131071;
    else if (y_wide < snd_pkg::Y_MIN) y_next = -18'sd131072;
    else                              y_next = y_wide[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= NT; j++) vld[j] <= 1'b0;
      done <= 1'b0;
    end else begin
      vld[0] <= start & ~busy;
      for (int j = 1; j <= NT; j++) vld[j] <= vld[j-1];
      done <= vld[NT];
    end
  end

  // Payload advances every cycle; valid bits mark live entries.
  always_ff @(posedge clk) begin
    s_q[0]   <= SIG_ROM[addr];
    row_q[0] <= row_sel;
    for (int j = 1; j < NT - 1; j++) begin
      s_q[j]   <= s_q[j-1];
    end
    for (int j = 1; j < NT; j++) begin
      p_q[j]   <= p_next[j];
    end
    for (int j = 1; j <= NT; j++) begin
      row_q[j] <= row_q[j-1];
      acc_q[j] <= acc_next[j];
    end
    y_out <= y_next;
  end

  // Every accepted sample yields a result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(snd_pkg::LATENCY) done)
    else $error("result missing after accepted sample");

  // No result without a matching earlier accepted sample.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, snd_pkg::LATENCY))
    else $error("result without matching sample");

  // Plain sigmoid is never negative.
  a_plain_nonneg: assert property (@(posedge clk) disable iff (rst)
    (vld[NT] && row_q[NT] == 3'd0) |=> (done && !y_out[17]))
    else $error("plain sigmoid result negative");

endmodule
